// File: sv/triangle_unit_normal_defines.svh
// ----------------------------------------------------------------------------
// Triangle unit normal assertion macros
// Shared concurrent assertion forms for the triangle normal pipeline.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TUN_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TUN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/tun_pkg.sv
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Shared types and constants of the triangle normal pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tun_pkg;

	localparam int COORD_WIDTH_DEF      = 16;
	localparam int NORMAL_FRAC_BITS_DEF = 14;

	localparam int FIELD_W = 16;  // width of every corner and normal field
	localparam int MAG_W   = 31;  // normalized cross magnitude width
	localparam int SUM_W   = 64;  // squared length width
	localparam int ROOT_W  = 32;  // length width

	typedef struct packed {
		logic signed [FIELD_W-1:0] a_x;
		logic signed [FIELD_W-1:0] a_y;
		logic signed [FIELD_W-1:0] a_z;
		logic signed [FIELD_W-1:0] b_x;
		logic signed [FIELD_W-1:0] b_y;
		logic signed [FIELD_W-1:0] b_z;
		logic signed [FIELD_W-1:0] c_x;
		logic signed [FIELD_W-1:0] c_y;
		logic signed [FIELD_W-1:0] c_z;
	} corner_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] normal_x;
		logic signed [FIELD_W-1:0] normal_y;
		logic signed [FIELD_W-1:0] normal_z;
		logic                      degenerate;
	} normal_t;

	// Normalized cross vector as sign and magnitude per component.
	typedef struct packed {
		logic [2:0]            neg;
		logic                  deg;
		logic [2:0][MAG_W-1:0] mag;
	} vec_t;

endpackage

`default_nettype wire

// File: sv/tun_cross.sv
// ----------------------------------------------------------------------------
// Triangle unit normal cross product
// Edge vectors, six products, cross components and sign/magnitude split.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_cross import tun_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int MW          = 2 * COORD_WIDTH + 3
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 vld,
	input  wire corner_t              corner,
	output logic                      vld_out,
	output logic [2:0]                neg_out,
	output logic [2:0][MW-1:0]        mag_out
);

	localparam int EW  = COORD_WIDTH + 1;
	localparam int PW  = 2 * EW;

	function automatic logic signed [EW-1:0] ext(input logic [FIELD_W-1:0] x);
		logic [EW-1:0] v;
		for (int i = 0; i < EW; i++) begin
			if (i < COORD_WIDTH && i < FIELD_W) v[i] = x[i % FIELD_W];
			else if (COORD_WIDTH <= FIELD_W) v[i] = x[(COORD_WIDTH - 1) % FIELD_W];
			else v[i] = 1'b0;
		end
		return v;
	endfunction

	logic signed [EW-1:0]   e1x_s1, e1y_s1, e1z_s1, e2x_s1, e2y_s1, e2z_s1;
	logic signed [PW-1:0]   p_s2 [6];
	logic signed [MW-1:0]   cr_s3 [3];
	logic [3:0]             vld_q;
	logic [2:0]             neg_s4;
	logic [2:0][MW-1:0]     mag_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[2:0], vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e1x_s1 <= ext(corner.b_x) - ext(corner.a_x);
			e1y_s1 <= ext(corner.b_y) - ext(corner.a_y);
			e1z_s1 <= ext(corner.b_z) - ext(corner.a_z);
			e2x_s1 <= ext(corner.c_x) - ext(corner.a_x);
			e2y_s1 <= ext(corner.c_y) - ext(corner.a_y);
			e2z_s1 <= ext(corner.c_z) - ext(corner.a_z);

			p_s2[0] <= PW'(e1y_s1) * PW'(e2z_s1);
			p_s2[1] <= PW'(e2y_s1) * PW'(e1z_s1);
			p_s2[2] <= PW'(e1z_s1) * PW'(e2x_s1);
			p_s2[3] <= PW'(e2z_s1) * PW'(e1x_s1);
			p_s2[4] <= PW'(e1x_s1) * PW'(e2y_s1);
			p_s2[5] <= PW'(e2x_s1) * PW'(e1y_s1);

			for (int i = 0; i < 3; i++) begin
				cr_s3[i] <= MW'(p_s2[2*i]) - MW'(p_s2[2*i+1]);
			end

			for (int i = 0; i < 3; i++) begin
				neg_s4[i] <= cr_s3[i][MW-1];
				mag_s4[i] <= cr_s3[i][MW-1] ? MW'(-cr_s3[i]) : MW'(cr_s3[i]);
			end
		end
	end

	assign vld_out = vld_q[3];
	assign neg_out = neg_s4;
	assign mag_out = mag_s4;

endmodule

`default_nettype wire

// File: sv/tun_norm.sv
// ----------------------------------------------------------------------------
// Triangle unit normal range scaler
// Scales the cross vector so its largest magnitude sits in [2^30, 2^31)
// and forms the squared length.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_norm import tun_pkg::*; #(
	parameter int MW = 35
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              vld,
	input  wire logic [2:0]        neg,
	input  wire logic [2:0][MW-1:0] mag,
	output logic                   vld_out,
	output vec_t                   vec_out,
	output logic [SUM_W-1:0]       sum_out
);

	localparam int BLW = $clog2(MW + 1);

	logic [4:0]              vld_q;
	logic [2:0]              neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic                    deg_s2, deg_s3, deg_s4, deg_s5;
	logic [2:0][MW-1:0]      mag_s1, mag_s2;
	logic [MW-1:0]           max_s1;
	logic [BLW-1:0]          blen_s2;
	logic [2:0][MAG_W-1:0]   mag_s3, mag_s4, mag_s5;
	logic [2*MAG_W-1:0]      sq_s4 [3];
	logic [SUM_W-1:0]        sum_s5;
	logic [MW-1:0]           max_c;
	logic [BLW-1:0]          blen_c;
	logic [MW+MAG_W-1:0]     wide_c [3];

	always_comb begin
		max_c = mag[0];
		if (mag[1] > max_c) max_c = mag[1];
		if (mag[2] > max_c) max_c = mag[2];
	end

	always_comb begin
		blen_c = '0;
		for (int i = 0; i < MW; i++) begin
			if (max_s1[i]) blen_c = BLW'(i + 1);
		end
	end

	// Left by 31-b or right by b-31 in a single right shift.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wide_c[i] = {mag_s2[i], {MAG_W{1'b0}}} >> blen_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[3:0], vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= neg;
			mag_s1 <= mag;
			max_s1 <= max_c;

			neg_s2  <= neg_s1;
			mag_s2  <= mag_s1;
			deg_s2  <= (max_s1 == '0);
			blen_s2 <= blen_c;

			neg_s3 <= neg_s2;
			deg_s3 <= deg_s2;
			for (int i = 0; i < 3; i++) mag_s3[i] <= wide_c[i][MAG_W-1:0];

			neg_s4 <= neg_s3;
			deg_s4 <= deg_s3;
			mag_s4 <= mag_s3;
			for (int i = 0; i < 3; i++) sq_s4[i] <= mag_s3[i] * mag_s3[i];

			neg_s5 <= neg_s4;
			deg_s5 <= deg_s4;
			mag_s5 <= mag_s4;
			sum_s5 <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
		end
	end

	assign vld_out     = vld_q[4];
	assign vec_out.neg = neg_s5;
	assign vec_out.deg = deg_s5;
	assign vec_out.mag = mag_s5;
	assign sum_out     = sum_s5;

endmodule

`default_nettype wire

// File: sv/tun_sqrt.sv
// ----------------------------------------------------------------------------
// Triangle unit normal square root
// Floor square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_sqrt import tun_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             vld,
	input  wire vec_t             vec,
	input  wire logic [SUM_W-1:0] sum,
	output logic                  vld_out,
	output vec_t                  vec_out,
	output logic [ROOT_W-1:0]     root_out
);

	localparam int NS = ROOT_W;

	logic [NS-1:0]    vld_q;
	logic [SUM_W-1:0] rem_s  [NS];
	logic [SUM_W-1:0] acc_s  [NS];
	vec_t             vec_s  [NS];
	logic [SUM_W-1:0] rem_c  [NS];
	logic [SUM_W-1:0] acc_c  [NS];

	always_comb begin
		for (int k = 0; k < NS; k++) begin
			logic [SUM_W-1:0] r, a, b;
			logic [SUM_W:0]   t;
			r = (k == 0) ? sum : rem_s[(k == 0) ? 0 : k - 1];
			a = (k == 0) ? '0  : acc_s[(k == 0) ? 0 : k - 1];
			b = SUM_W'(1) << (SUM_W - 2 - 2 * k);
			t = {1'b0, a} + {1'b0, b};
			if ({1'b0, r} >= t) begin
				rem_c[k] = r - t[SUM_W-1:0];
				acc_c[k] = (a >> 1) + b;
			end else begin
				rem_c[k] = r;
				acc_c[k] = a >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NS-2:0], vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NS; k++) begin
				rem_s[k] <= rem_c[k];
				acc_s[k] <= acc_c[k];
				vec_s[k] <= (k == 0) ? vec : vec_s[(k == 0) ? 0 : k - 1];
			end
		end
	end

	assign vld_out  = vld_q[NS-1];
	assign vec_out  = vec_s[NS-1];
	assign root_out = acc_s[NS-1][ROOT_W-1:0];

endmodule

`default_nettype wire

// File: sv/tun_div.sv
// ----------------------------------------------------------------------------
// Triangle unit normal divider
// Three-lane restoring divider, one quotient bit per stage, with rounding
// added to the dividend on entry and saturation and sign in the last stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_div import tun_pkg::*; #(
	parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              vld,
	input  wire vec_t              vec,
	input  wire logic [ROOT_W-1:0] root,
	output logic                   vld_out,
	output normal_t                normal_out
);

	localparam int QW = NORMAL_FRAC_BITS + 1;
	localparam int NW = QW + MAG_W;
	localparam int XW = QW + FIELD_W;

	logic [QW+1:0]          vld_q;
	logic [2:0][ROOT_W-1:0] rem_s [QW+1];
	logic [2:0][QW-1:0]     low_s [QW+1];
	logic [ROOT_W-1:0]      div_s [QW+1];
	logic [2:0]             neg_s [QW+1];
	logic                   deg_s [QW+1];
	logic [2:0][ROOT_W-1:0] rem_c [QW];
	logic [2:0][QW-1:0]     low_c [QW];
	logic [2:0][NW-1:0]     num_c;
	normal_t                out_s;
	normal_t                out_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_c[i] = (NW'(vec.mag[i]) << NORMAL_FRAC_BITS) + NW'(root >> 1);
		end
	end

	always_comb begin
		for (int k = 0; k < QW; k++) begin
			for (int i = 0; i < 3; i++) begin
				logic [ROOT_W:0] t;
				t = {rem_s[k][i], low_s[k][i][QW-1]};
				if (t >= {1'b0, div_s[k]}) begin
					rem_c[k][i] = ROOT_W'(t - {1'b0, div_s[k]});
					low_c[k][i] = {low_s[k][i][QW-2:0], 1'b1};
				end else begin
					rem_c[k][i] = t[ROOT_W-1:0];
					low_c[k][i] = {low_s[k][i][QW-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		logic [XW-1:0]      qx;
		logic [FIELD_W-1:0] m [3];
		for (int i = 0; i < 3; i++) begin
			qx   = XW'(low_s[QW][i]);
			m[i] = (qx > XW'(32767)) ? 16'h7FFF : qx[FIELD_W-1:0];
			if (deg_s[QW]) m[i] = '0;
			else if (neg_s[QW][i]) m[i] = -m[i];
		end
		out_c.normal_x   = m[0];
		out_c.normal_y   = m[1];
		out_c.normal_z   = m[2];
		out_c.degenerate = deg_s[QW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[QW:0], vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rem_s[0][i] <= ROOT_W'(num_c[i] >> QW);
				low_s[0][i] <= num_c[i][QW-1:0];
			end
			div_s[0] <= root;
			neg_s[0] <= vec.neg;
			deg_s[0] <= vec.deg;
			for (int k = 0; k < QW; k++) begin
				rem_s[k+1] <= rem_c[k];
				low_s[k+1] <= low_c[k];
				div_s[k+1] <= div_s[k];
				neg_s[k+1] <= neg_s[k];
				deg_s[k+1] <= deg_s[k];
			end
			out_s <= out_c;
		end
	end

	assign vld_out    = vld_q[QW+1];
	assign normal_out = out_s;

endmodule

`default_nettype wire

// File: sv/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// Triangle unit normal
// Unit face normal of a triangle given as three signed Q8.8 corners.
// ----------------------------------------------------------------------------
// The block takes one triangle per clock cycle and returns its unit normal in
// signed Q1.14 (NORMAL_FRAC_BITS fraction bits), in order, one result per
// triangle. Each triangle passes the cross product, the range scaler, the
// 32-stage square root, which resolves one bit of the length per stage, and
// the divider, which resolves one quotient bit per stage. The whole pipeline
// advances together; a two-entry output buffer lets the block keep taking
// corners while one finished normal waits to be transferred, and
// corner_ready drops only when both entries are full. A triangle whose cross
// product is exactly zero returns a zero normal with degenerate set.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_unit_normal import tun_pkg::*; #(
	parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
	parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    corner_valid,
	output logic         corner_ready,
	input  wire corner_t corner_data,
	output logic         normal_valid,
	input  wire logic    normal_ready,
	output normal_t      normal_data
);

`include "triangle_unit_normal_defines.svh"

	// Magnitude width of an exact cross product component.
	localparam int MW = 2 * COORD_WIDTH + 3;

	logic               en;
	logic               cross_vld, norm_vld, sqrt_vld, div_vld;
	logic [2:0]         cross_neg;
	logic [2:0][MW-1:0] cross_mag;
	vec_t               norm_vec, sqrt_vec;
	logic [SUM_W-1:0]   norm_sum;
	logic [ROOT_W-1:0]  sqrt_root;
	normal_t            div_normal;

	logic               out_valid_q, skid_valid_q;
	normal_t            out_q, skid_q;
	logic               push;

	// The pipeline moves as one; it halts only when the skid entry holds a
	// result, so nothing in flight is ever dropped or repeated.
	assign en           = !skid_valid_q;
	assign corner_ready = en;
	assign push         = en && div_vld;

	tun_cross #(
		.COORD_WIDTH (COORD_WIDTH),
		.MW          (MW)
	) u_cross (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld     (corner_valid),
		.corner  (corner_data),
		.vld_out (cross_vld),
		.neg_out (cross_neg),
		.mag_out (cross_mag)
	);

	tun_norm #(
		.MW (MW)
	) u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld     (cross_vld),
		.neg     (cross_neg),
		.mag     (cross_mag),
		.vld_out (norm_vld),
		.vec_out (norm_vec),
		.sum_out (norm_sum)
	);

	tun_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld      (norm_vld),
		.vec      (norm_vec),
		.sum      (norm_sum),
		.vld_out  (sqrt_vld),
		.vec_out  (sqrt_vec),
		.root_out (sqrt_root)
	);

	tun_div #(
		.NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.vld        (sqrt_vld),
		.vec        (sqrt_vec),
		.root       (sqrt_root),
		.vld_out    (div_vld),
		.normal_out (div_normal)
	);

	// Output register plus skid entry. The output register refills from the
	// skid entry first so results leave in order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || normal_ready) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || normal_ready) begin
			out_q <= skid_valid_q ? skid_q : div_normal;
		end else if (push) begin
			skid_q <= div_normal;
		end
	end

	assign normal_valid = out_valid_q;
	assign normal_data  = out_q;

	`TUN_ASSERT_SAME(a_skid_behind_out, skid_valid_q, out_valid_q, "skid entry full while output empty")
	`TUN_ASSERT_NEXT(a_skid_delivers, skid_valid_q, out_valid_q, "skid result lost")
	`TUN_ASSERT_SAME(a_degenerate_zero, normal_valid && normal_data.degenerate, normal_data.normal_x == '0 && normal_data.normal_y == '0 && normal_data.normal_z == '0, "degenerate normal not zero")

endmodule

`default_nettype wire
